### hw/rtl/iac_pkg.sv
// Shared types and codes for the intrusion alarm controller.
// Depends on nothing; every other file of the block but iac_if.sv imports it.
package iac_pkg;

    // Item kinds on the event channel
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;

    // Keypad codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_STAR      = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;

    // Configuration register indexes
    localparam logic [2:0] REG_ARM_CODE      = 3'd0;
    localparam logic [2:0] REG_DISARM_CODE   = 3'd1;
    localparam logic [2:0] REG_EXIT_DELAY    = 3'd2;
    localparam logic [2:0] REG_ENTRY_DELAY   = 3'd3;
    localparam logic [2:0] REG_SIREN_TIME    = 3'd4;
    localparam logic [2:0] REG_TICKS_PER_SEC = 3'd5;

    localparam int CODE_W = 14;
    localparam int ZONES  = 6;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMING   = 2'd1,
        MODE_ARMED    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        RES_NONE      = 3'd0,
        RES_ARMING    = 3'd1,
        RES_HOUSE_OPEN = 3'd2,
        RES_DISARMED  = 3'd3,
        RES_WRONG     = 3'd4
    } key_result_t;

    typedef struct packed {
        logic [CODE_W-1:0] arm_code;
        logic [CODE_W-1:0] disarm_code;
        logic [7:0]        exit_delay_s;
        logic [7:0]        entry_delay_s;
        logic [7:0]        siren_time_s;
        logic [3:0]        ticks_per_second;
    } cfg_t;

    typedef struct packed {
        logic             buzzer_on;
        logic             siren_on;
        logic             armed_lamp;
        logic [ZONES-1:0] zone_lamps;
        logic [1:0]       mode;
        logic [2:0]       key_result;
    } res_t;

endpackage

### hw/rtl/iac_if.sv
// Valid/ready channel interfaces of the intrusion alarm controller.
// Event items in, panel status items out; no package dependency.
interface iac_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] key;
    logic [5:0] contacts;

    modport source (output valid, output cmd, output key, output contacts, input ready);
    modport sink (input valid, input cmd, input key, input contacts, output ready);
endinterface

interface iac_status_if;
    logic       valid;
    logic       ready;
    logic       buzzer_on;
    logic       siren_on;
    logic       armed_lamp;
    logic [5:0] zone_lamps;
    logic [1:0] mode;
    logic [2:0] key_result;

    modport source (output valid, output buzzer_on, output siren_on, output armed_lamp,
                    output zone_lamps, output mode, output key_result, input ready);
    modport sink (input valid, input buzzer_on, input siren_on, input armed_lamp,
                  input zone_lamps, input mode, input key_result, output ready);
endinterface

### hw/rtl/iac_cfg_regs.sv
// Configuration register file of the intrusion alarm controller.
// Depends on iac_pkg for cfg_t and the register indexes.
module iac_cfg_regs
    import iac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CODE_W-1:0]   cfg_wdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_code         <= 14'd33;
            cfg_reg.disarm_code      <= 14'd1664;
            cfg_reg.exit_delay_s     <= 8'd5;
            cfg_reg.entry_delay_s    <= 8'd5;
            cfg_reg.siren_time_s     <= 8'd10;
            cfg_reg.ticks_per_second <= 4'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ARM_CODE:      cfg_reg.arm_code         <= cfg_wdata;
                REG_DISARM_CODE:   cfg_reg.disarm_code      <= cfg_wdata;
                REG_EXIT_DELAY:    cfg_reg.exit_delay_s     <= cfg_wdata[7:0];
                REG_ENTRY_DELAY:   cfg_reg.entry_delay_s    <= cfg_wdata[7:0];
                REG_SIREN_TIME:    cfg_reg.siren_time_s     <= cfg_wdata[7:0];
                REG_TICKS_PER_SEC: cfg_reg.ticks_per_second <= cfg_wdata[3:0];
                default:           ; // index beyond the list: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/iac_core.sv
// Panel state and per-item update logic of the intrusion alarm controller.
// Depends on iac_pkg; the result it returns is the status after the item.
module iac_core
    import iac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             step,
    input  logic [1:0]       cmd,
    input  logic [3:0]       key,
    input  logic [ZONES-1:0] contacts,
    output res_t             res
);

    typedef enum logic [1:0] {
        SIREN_IDLE     = 2'd0,
        SIREN_SOUNDING = 2'd1,
        SIREN_DONE     = 2'd2
    } siren_t;

    localparam logic signed [8:0] CNT_IDLE = -9'sd1;

    logic [3:0]           tick_count_reg,   tick_count_next;
    logic [CODE_W-1:0]    entered_code_reg, entered_code_next;
    mode_t                mode_reg,         mode_next;
    logic signed [8:0]    exit_count_reg,   exit_count_next;
    logic signed [8:0]    entry_count_reg,  entry_count_next;
    logic signed [8:0]    siren_count_reg,  siren_count_next;
    siren_t               siren_mode_reg,   siren_mode_next;
    logic [ZONES-1:0]     zone_reg,         zone_next;
    logic                 buzzer_reg,       buzzer_next;
    logic                 siren_lamp_reg,   siren_lamp_next;
    logic                 armed_lamp_reg,   armed_lamp_next;
    key_result_t          key_result;

    // Remainder of a code below 10000 modulo 1000
    function automatic logic [9:0] low_three_digits(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] r;
        r = v;
        for (int k = 1; k <= 9; k++)
        begin
            if (v >= CODE_W'(k * 1000))
                r = v - CODE_W'(k * 1000);
        end
        return r[9:0];
    endfunction

    function automatic logic signed [8:0] count_down(input logic signed [8:0] c);
        return (c > 9'sd0) ? c - 9'sd1 : c;
    endfunction

    always_comb
    begin
        logic [ZONES-1:0] open;
        logic [3:0]       tick_inc;
        logic             window_hit;

        tick_count_next   = tick_count_reg;
        entered_code_next = entered_code_reg;
        mode_next         = mode_reg;
        exit_count_next   = exit_count_reg;
        entry_count_next  = entry_count_reg;
        siren_count_next  = siren_count_reg;
        siren_mode_next   = siren_mode_reg;
        zone_next         = zone_reg;
        buzzer_next       = buzzer_reg;
        siren_lamp_next   = siren_lamp_reg;
        armed_lamp_next   = armed_lamp_reg;
        key_result        = RES_NONE;
        open              = ~contacts;
        tick_inc          = tick_count_reg + 4'd1;
        window_hit        = 1'b0;

        // Apply the event
        if (cmd == CMD_TICK)
        begin
            tick_count_next = tick_inc;
            if (tick_inc >= cfg.ticks_per_second)
            begin
                tick_count_next  = 4'd0;
                exit_count_next  = count_down(exit_count_reg);
                siren_count_next = count_down(siren_count_reg);
                entry_count_next = count_down(entry_count_reg);
            end
        end
        else if (cmd == CMD_KEY)
        begin
            if (key <= KEY_DIGIT_MAX)
                entered_code_next = CODE_W'(low_three_digits(entered_code_reg)) * CODE_W'(10)
                                    + CODE_W'(key);
            else if (key == KEY_STAR)
                entered_code_next = '0;
            else if (key == KEY_HASH)
            begin
                entered_code_next = '0;
                if (entered_code_reg == cfg.arm_code)
                begin
                    zone_next        = '0;
                    siren_lamp_next  = 1'b0;
                    exit_count_next  = CNT_IDLE;
                    entry_count_next = CNT_IDLE;
                    siren_count_next = CNT_IDLE;
                    siren_mode_next  = SIREN_IDLE;
                    if (&contacts)
                    begin
                        mode_next       = MODE_ARMING;
                        exit_count_next = 9'($unsigned(cfg.exit_delay_s));
                        buzzer_next     = 1'b1;
                        armed_lamp_next = 1'b0;
                        key_result      = RES_ARMING;
                    end
                    else
                        key_result = RES_HOUSE_OPEN;
                end
                else if (entered_code_reg == cfg.disarm_code)
                begin
                    mode_next       = MODE_DISARMED;
                    buzzer_next     = 1'b0;
                    siren_lamp_next = 1'b0;
                    armed_lamp_next = 1'b0;
                    key_result      = RES_DISARMED;
                end
                else
                    key_result = RES_WRONG;
            end
        end

        // Evaluation pass with this item's contacts
        if (exit_count_next == 9'sd0 && mode_next == MODE_ARMING)
        begin
            mode_next       = MODE_ARMED;
            buzzer_next     = 1'b0;
            armed_lamp_next = 1'b1;
        end
        if (siren_mode_next == SIREN_SOUNDING && siren_count_next == 9'sd0)
        begin
            siren_mode_next = SIREN_DONE;
            siren_lamp_next = 1'b0;
        end
        if (entry_count_next == 9'sd0 && mode_next == MODE_ARMED)
        begin
            if (siren_mode_next == SIREN_IDLE)
            begin
                siren_count_next = 9'($unsigned(cfg.siren_time_s));
                siren_mode_next  = SIREN_SOUNDING;
                siren_lamp_next  = 1'b1;
            end
            if (open[4])
                zone_next[4] = 1'b1;
            else if (open[5])
                zone_next[5] = 1'b1;
        end
        if (mode_next == MODE_ARMED)
        begin
            // First open window (lowest index) latches its lamp and starts an idle siren
            for (int i = 3; i >= 0; i--)
            begin
                if (open[i])
                    window_hit = 1'b1;
            end
            if (window_hit)
            begin
                priority if (open[0]) zone_next[0] = 1'b1;
                else if (open[1])     zone_next[1] = 1'b1;
                else if (open[2])     zone_next[2] = 1'b1;
                else                  zone_next[3] = 1'b1;
                if (siren_mode_next == SIREN_IDLE)
                begin
                    siren_count_next = 9'($unsigned(cfg.siren_time_s));
                    siren_mode_next  = SIREN_SOUNDING;
                    siren_lamp_next  = 1'b1;
                end
            end
            else if ((open[4] || open[5]) && entry_count_next < 9'sd0)
            begin
                buzzer_next      = 1'b1;
                entry_count_next = 9'($unsigned(cfg.entry_delay_s));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            entered_code_reg <= '0;
            mode_reg         <= MODE_ARMING;
            exit_count_reg   <= CNT_IDLE;
            entry_count_reg  <= CNT_IDLE;
            siren_count_reg  <= CNT_IDLE;
            siren_mode_reg   <= SIREN_IDLE;
            zone_reg         <= '0;
            buzzer_reg       <= 1'b0;
            siren_lamp_reg   <= 1'b0;
            armed_lamp_reg   <= 1'b0;
        end
        else if (step)
        begin
            tick_count_reg   <= tick_count_next;
            entered_code_reg <= entered_code_next;
            mode_reg         <= mode_next;
            exit_count_reg   <= exit_count_next;
            entry_count_reg  <= entry_count_next;
            siren_count_reg  <= siren_count_next;
            siren_mode_reg   <= siren_mode_next;
            zone_reg         <= zone_next;
            buzzer_reg       <= buzzer_next;
            siren_lamp_reg   <= siren_lamp_next;
            armed_lamp_reg   <= armed_lamp_next;
        end
    end

    assign res.buzzer_on  = buzzer_next;
    assign res.siren_on   = siren_lamp_next;
    assign res.armed_lamp = armed_lamp_next;
    assign res.zone_lamps = zone_next;
    assign res.mode       = mode_next;
    assign res.key_result = key_result;

    a_siren_lamp_sounding: assert property (@(posedge clk) disable iff (!rst_n)
        siren_lamp_reg |-> siren_mode_reg == SIREN_SOUNDING)
        else $error("siren lamp on without a sounding siren");

    a_armed_lamp_mode: assert property (@(posedge clk) disable iff (!rst_n)
        armed_lamp_reg |-> mode_reg == MODE_ARMED)
        else $error("armed lamp on outside armed mode");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        entered_code_reg < CODE_W'(10000))
        else $error("entered code left its decimal range");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(entered_code_reg) && $stable(zone_reg))
        else $error("panel state moved without an item");

endmodule

### hw/rtl/intrusion_alarm_controller_top.sv
// Intrusion alarm controller: top level with event and status channels.
// Accepted items wait in the input register and pass the update stage into the result
// register, which offers their status. Throughput: one item per cycle while the sink
// is ready, set by the single update stage of iac_core. A result held by a stalled sink
// blocks the update stage; one more item can still enter the input register.
// Reset (rst_n low, asynchronous): registers to defaults, panel arming, all off.
module intrusion_alarm_controller_top
    import iac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    iac_evt_if.sink             evt,
    iac_status_if.source        status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CODE_W-1:0]   cfg_wdata
);

    cfg_t             cfg;
    res_t             res;
    logic             advance;

    // Input register: holds one accepted item until the update stage takes it
    logic             in_valid_reg, in_valid_next;
    logic [1:0]       cmd_reg;
    logic [3:0]       key_reg;
    logic [ZONES-1:0] contacts_reg;

    // Result register: holds one status item for the sink
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;

    // The update stage fires when it has an item and the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || status.ready);
    assign evt.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (evt.valid && evt.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (status.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: item fields load on accept, the result on advance; no reset needed
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            cmd_reg      <= evt.cmd;
            key_reg      <= evt.key;
            contacts_reg <= evt.contacts;
        end
        if (advance)
            out_reg <= res;
    end

    iac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Panel state advances exactly once per item, as it moves to the result slot
    iac_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .step     (advance),
        .cmd      (cmd_reg),
        .key      (key_reg),
        .contacts (contacts_reg),
        .res      (res)
    );

    assign status.valid      = out_valid_reg;
    assign status.buzzer_on  = out_reg.buzzer_on;
    assign status.siren_on   = out_reg.siren_on;
    assign status.armed_lamp = out_reg.armed_lamp;
    assign status.zone_lamps = out_reg.zone_lamps;
    assign status.mode       = out_reg.mode;
    assign status.key_result = out_reg.key_result;

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result slot empty after an update");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cmd_reg) && $stable(key_reg))
        else $error("pending item lost while the result slot was full");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !status.ready |-> !advance)
        else $error("update stage overwrote an untaken result");

endmodule

### test/testbench.sv
// Self-checking bench for the intrusion alarm controller: a keypad, tick and contact
// item stream against a cycle-free panel predictor, with random stalls on both channels.
// Depends on iac_pkg, the iac_evt_if/iac_status_if channels and intrusion_alarm_controller_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iac_pkg::*;

    // Item kinds the package leaves unnamed: both only sample the contacts
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [5:0] ALL_CLOSED   = 6'h3F;
    localparam int         SETTLE_TAIL  = 4;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         REPORT_LIMIT = 100;
    localparam int         PHASE_ITEMS  = 125;
    localparam int         PHASES       = 8;

    typedef enum logic [1:0] {
        SIREN_QUIET,
        SIREN_SOUNDING,
        SIREN_SPENT
    } siren_phase_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_ARM_CODE;
    logic [CODE_W-1:0] cfg_wdata = '0;

    iac_evt_if    evt_ch ();
    iac_status_if status_ch ();

    intrusion_alarm_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_ch),
        .status    (status_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Panel predictor: its own copy of the registers and of the panel state
    // ------------------------------------------------------------------
    cfg_t         panel_cfg;
    logic [3:0]   tick_phase;
    int           code_buf;
    mode_t        panel_mode;
    int           exit_left;
    int           entry_left;
    int           siren_left;
    siren_phase_t siren_state;
    logic         lamp_buzzer;
    logic         lamp_siren;
    logic         lamp_armed;
    logic [5:0]   zone_latch;

    res_t status_due[$];    // predicted status items, oldest first

    int errors = 0;
    int items_sent = 0;
    int settings_used = 0;
    int arm_starts = 0;
    int siren_starts = 0;
    int cycle_count = 0;
    int send_calm = 0;
    int sink_calm = 0;

    function automatic void panel_reset();
        panel_cfg.arm_code         = 14'd33;
        panel_cfg.disarm_code      = 14'd1664;
        panel_cfg.exit_delay_s     = 8'd5;
        panel_cfg.entry_delay_s    = 8'd5;
        panel_cfg.siren_time_s     = 8'd10;
        panel_cfg.ticks_per_second = 4'd10;
        tick_phase  = '0;
        code_buf    = 0;
        panel_mode  = MODE_ARMING;
        exit_left   = -1;
        entry_left  = -1;
        siren_left  = -1;
        siren_state = SIREN_QUIET;
        lamp_buzzer = 1'b0;
        lamp_siren  = 1'b0;
        lamp_armed  = 1'b0;
        zone_latch  = '0;
    endfunction

    // Only an untriggered siren starts; a spent one stays silent until the next arm
    function automatic void sound_siren();
        if (siren_state == SIREN_QUIET)
        begin
            siren_left  = panel_cfg.siren_time_s;
            siren_state = SIREN_SOUNDING;
            lamp_siren  = 1'b1;
            siren_starts++;
        end
    endfunction

    function automatic res_t panel_step(logic [1:0] cmd, logic [3:0] key, logic [5:0] contacts);
        res_t        status;
        key_result_t answer;
        logic [5:0]  breached;
        bit          window_hit;
        answer     = RES_NONE;
        breached   = ~contacts;
        window_hit = 1'b0;

        // Apply the event of the item
        if (cmd == CMD_TICK)
        begin
            tick_phase = tick_phase + 4'd1;
            if (tick_phase >= panel_cfg.ticks_per_second)
            begin
                tick_phase = '0;
                if (exit_left > 0)
                    exit_left--;
                if (siren_left > 0)
                    siren_left--;
                if (entry_left > 0)
                    entry_left--;
            end
        end
        else if (cmd == CMD_KEY)
        begin
            if (key <= KEY_DIGIT_MAX)
                code_buf = (code_buf * 10 + int'(key)) % 10000;
            else if (key == KEY_STAR)
                code_buf = 0;
            else if (key == KEY_HASH)
            begin
                if (code_buf == int'(panel_cfg.arm_code))
                begin
                    zone_latch  = '0;
                    lamp_siren  = 1'b0;
                    exit_left   = -1;
                    entry_left  = -1;
                    siren_left  = -1;
                    siren_state = SIREN_QUIET;
                    if (contacts == ALL_CLOSED)
                    begin
                        panel_mode  = MODE_ARMING;
                        exit_left   = panel_cfg.exit_delay_s;
                        lamp_buzzer = 1'b1;
                        lamp_armed  = 1'b0;
                        answer      = RES_ARMING;
                        arm_starts++;
                    end
                    else
                        answer = RES_HOUSE_OPEN;
                end
                else if (code_buf == int'(panel_cfg.disarm_code))
                begin
                    panel_mode  = MODE_DISARMED;
                    lamp_buzzer = 1'b0;
                    lamp_siren  = 1'b0;
                    lamp_armed  = 1'b0;
                    answer      = RES_DISARMED;
                end
                else
                    answer = RES_WRONG;
                code_buf = 0;
            end
        end

        // One evaluation pass with the contacts of this item
        if (exit_left == 0 && panel_mode == MODE_ARMING)
        begin
            panel_mode  = MODE_ARMED;
            lamp_buzzer = 1'b0;
            lamp_armed  = 1'b1;
        end
        if (siren_state == SIREN_SOUNDING && siren_left == 0)
        begin
            siren_state = SIREN_SPENT;
            lamp_siren  = 1'b0;
        end
        if (entry_left == 0 && panel_mode == MODE_ARMED)
        begin
            sound_siren();
            if (breached[4])
                zone_latch[4] = 1'b1;
            else if (breached[5])
                zone_latch[5] = 1'b1;
        end
        if (panel_mode == MODE_ARMED)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (!window_hit && breached[i])
                begin
                    zone_latch[i] = 1'b1;
                    sound_siren();
                    window_hit = 1'b1;
                end
            end
            if (!window_hit && breached[5:4] != 2'b00 && entry_left < 0)
            begin
                lamp_buzzer = 1'b1;
                entry_left  = panel_cfg.entry_delay_s;
            end
        end

        status.buzzer_on  = lamp_buzzer;
        status.siren_on   = lamp_siren;
        status.armed_lamp = lamp_armed;
        status.zone_lamps = zone_latch;
        status.mode       = panel_mode;
        status.key_result = answer;
        return status;
    endfunction

    // ------------------------------------------------------------------
    // Channel pacing: random waits, with runs of back-to-back items
    // ------------------------------------------------------------------
    function automatic int pick_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Send one event item: hold valid until the block takes it, then predict its status.
    // Valid is left high on return so a back-to-back item keeps it up without a dip.
    task automatic send_item(logic [1:0] cmd, logic [3:0] key, logic [5:0] contacts);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid    <= 1'b1;
        evt_ch.cmd      <= cmd;
        evt_ch.key      <= key;
        evt_ch.contacts <= contacts;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        status_due.push_back(panel_step(cmd, key, contacts));
        items_sent++;
    endtask

    // Drop valid and wait until every predicted status item has come back
    task automatic settle();
        evt_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value[CODE_W-1:0];
        @(posedge clk);
    endtask

    // Write all six registers back to back while the panel is idle
    task automatic program_panel(int arm, int disarm, int exit_s, int entry_s, int siren_s,
                                 int tps);
        settle();
        write_reg(REG_ARM_CODE, arm);
        write_reg(REG_DISARM_CODE, disarm);
        write_reg(REG_EXIT_DELAY, exit_s);
        write_reg(REG_ENTRY_DELAY, entry_s);
        write_reg(REG_SIREN_TIME, siren_s);
        write_reg(REG_TICKS_PER_SEC, tps);
        cfg_we <= 1'b0;
        panel_cfg.arm_code         = arm[CODE_W-1:0];
        panel_cfg.disarm_code      = disarm[CODE_W-1:0];
        panel_cfg.exit_delay_s     = exit_s[7:0];
        panel_cfg.entry_delay_s    = entry_s[7:0];
        panel_cfg.siren_time_s     = siren_s[7:0];
        panel_cfg.ticks_per_second = tps[3:0];
        settings_used++;
    endtask

    // Four digits, most significant first; earlier digits shift out of the code
    task automatic type_code(int code, logic [5:0] contacts);
        int digit;
        for (int p = 1000; p > 0; p /= 10)
        begin
            digit = (code / p) % 10;
            send_item(CMD_KEY, digit[3:0], contacts);
        end
    endtask

    task automatic press_hash(logic [5:0] contacts);
        send_item(CMD_KEY, KEY_HASH, contacts);
    endtask

    task automatic tick_run(int count, logic [5:0] contacts);
        repeat (count) send_item(CMD_TICK, 4'($urandom), contacts);
    endtask

    // Ticks that cover a delay of the given seconds, capped to keep sessions short
    function automatic int ticks_for(int secs);
        int per_sec;
        int count;
        per_sec = (panel_cfg.ticks_per_second == 0) ? 1 : panel_cfg.ticks_per_second;
        count   = secs * per_sec;
        if (count > 40)
            count = 40;
        return count + $urandom_range(0, 2);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: star, an ignored key, wrong code, house open, code overflow into a disarm, a spare item
    task automatic test_keypad();
        send_item(CMD_KEY, KEY_STAR, ALL_CLOSED);
        send_item(CMD_KEY, 4'd15, 6'h00);
        press_hash(ALL_CLOSED);
        type_code(33, ALL_CLOSED);
        press_hash(6'h1F);
        send_item(CMD_KEY, 4'd9, ALL_CLOSED);
        type_code(1664, ALL_CLOSED);
        press_hash(ALL_CLOSED);
        send_item(CMD_SPARE, 4'hF, 6'h00);
    endtask

    // Arm, run out the exit delay, open a door through its entry delay to the siren,
    // let the siren end, then open a window after the siren is spent
    task automatic test_arm_and_alarm();
        program_panel(0, 9999, 1, 2, 1, 1);
        press_hash(ALL_CLOSED);
        tick_run(1, ALL_CLOSED);
        send_item(CMD_SAMPLE, 4'd0, 6'h2F);
        tick_run(2, 6'h2F);
        tick_run(1, ALL_CLOSED);
        send_item(CMD_SAMPLE, 4'd0, 6'h37);
    endtask

    // Zero exit delay ends in the same pass, entry and siren on a later item; equal codes arm; every tick is a second
    task automatic test_zero_delays();
        program_panel(0, 0, 0, 0, 0, 0);
        press_hash(ALL_CLOSED);
        send_item(CMD_SAMPLE, 4'd0, 6'h1F);
        send_item(CMD_SAMPLE, 4'd0, 6'h1F);
        send_item(CMD_TICK, 4'd0, 6'h1F);
    endtask

    // One random session: mostly a full arm / break-in / disarm sequence
    task automatic run_session();
        int         pick;
        int         burst;
        logic [5:0] breach;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_KEY, KEY_STAR, ALL_CLOSED);
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_KEY, 4'($urandom_range(0, 9)), ALL_CLOSED);
            type_code(panel_cfg.arm_code, ALL_CLOSED);
            press_hash(($urandom_range(0, 5) == 0) ? 6'($urandom) : ALL_CLOSED);
            tick_run(ticks_for(panel_cfg.exit_delay_s), ALL_CLOSED);
            breach = ALL_CLOSED ^ (6'd1 << $urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0)
                breach = breach & 6'($urandom);
            send_item(CMD_SAMPLE, 4'($urandom), breach);
            tick_run(ticks_for(panel_cfg.entry_delay_s + panel_cfg.siren_time_s),
                     ($urandom_range(0, 1) == 0) ? breach : ALL_CLOSED);
            if ($urandom_range(0, 3) != 0)
            begin
                type_code(panel_cfg.disarm_code, ALL_CLOSED);
                press_hash(ALL_CLOSED);
            end
        end
        else if (pick < 8)
        begin
            // Disarm attempt, sometimes with a code that is most likely wrong
            type_code(($urandom_range(0, 2) == 0) ? $urandom_range(0, 9999)
                                                  : panel_cfg.disarm_code,
                      6'($urandom));
            press_hash(6'($urandom));
        end
        else
        begin
            // Noise: any kind, any key, any contacts
            burst = $urandom_range(1, 8);
            repeat (burst)
                send_item(2'($urandom), 4'($urandom), 6'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_panel(9999, 0, 255, 255, 255, 15);
                1: program_panel(0, 9999, 1, 1, 1, 1);
                2: program_panel(4321, 4321, 0, 0, 0, 0);
                default:
                    program_panel($urandom_range(0, 9999), $urandom_range(0, 9999),
                                  $urandom_range(1, 4), $urandom_range(1, 4),
                                  $urandom_range(1, 4), $urandom_range(1, 3));
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_session();
        end
    endtask

    // ------------------------------------------------------------------
    // Status side: random ready stalls, and compare each item taken
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [5:0] want, logic [5:0] got);
        if (got !== want)
        begin
            if (errors < REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_status();
        res_t want;
        if (status_due.size() == 0)
        begin
            if (errors < REPORT_LIMIT)
                $error("status item arrived with no event item pending");
            errors++;
            return;
        end
        want = status_due.pop_front();
        compare_field("buzzer_on", want.buzzer_on, status_ch.buzzer_on);
        compare_field("siren_on", want.siren_on, status_ch.siren_on);
        compare_field("armed_lamp", want.armed_lamp, status_ch.armed_lamp);
        compare_field("zone_lamps", want.zone_lamps, status_ch.zone_lamps);
        compare_field("mode", want.mode, status_ch.mode);
        compare_field("key_result", want.key_result, status_ch.key_result);
    endfunction

    // Values read right after the edge are the ones the edge sampled
    initial
    begin : status_sink
        int stall;
        stall = 0;
        status_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        status_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (status_ch.valid && status_ch.ready)
            begin
                check_status();
                stall = pick_wait(sink_calm);
                if (stall > 0)
                    status_ch.ready <= 1'b0;
            end
            else if (!status_ch.ready)
            begin
                stall--;
                if (stall <= 0)
                    status_ch.ready <= 1'b1;
            end
        end
    end

    // Hard stop for a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed tests, random phases, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        evt_ch.valid    <= 1'b0;
        evt_ch.cmd      <= CMD_TICK;
        evt_ch.key      <= '0;
        evt_ch.contacts <= ALL_CLOSED;
        panel_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keypad();
        test_arm_and_alarm();
        test_zero_delays();
        test_random_traffic();
        settle();

        $display("Covered %0d items over %0d register settings plus the reset values,",
                 items_sent, settings_used);
        $display("with %0d arming starts and %0d siren starts.", arm_starts, siren_starts);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
